// ----- rtl/pcp_pkg.sv -----
`default_nettype none

package pcp_pkg;

  localparam int unsigned COEFF_COUNT = 256;
  localparam int unsigned MODULUS     = 3329;

  localparam int unsigned COEFF_W = 16;
  localparam int unsigned VALUE_W = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PEND_W  = BYTE_W - 1;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned IDX_W   = $clog2(COEFF_COUNT);
  localparam int unsigned MOD_W   = $clog2(MODULUS);

  // exact floor division of any 16-bit value by the modulus
  localparam int unsigned RECIP_SHIFT = COEFF_W + MOD_W;
  localparam int unsigned RECIP_W     = COEFF_W + 1;
  localparam int unsigned PROD_W      = COEFF_W + RECIP_W;
  localparam longint unsigned RECIP   =
    ((64'd1 << RECIP_SHIFT) + MODULUS - 1) / MODULUS;

  localparam int unsigned THR_COUNT = 1 << VALUE_W;
  localparam int unsigned THR_W     = MOD_W + 1;

  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
  } value_t;

  // smallest reduced x whose rounded 8x/q reaches k
  function automatic logic [THR_W-1:0] compress_threshold(input int unsigned k);
    int unsigned num;
    num = k * MODULUS - MODULUS / 2;
    return THR_W'((num + 7) / 8);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pcp_reduce.sv -----
`default_nettype none

module pcp_reduce
  import pcp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic [COEFF_W-1:0] coefficient_i,
  output value_t                  value_o
);

  localparam logic [RECIP_W-1:0] RecipC = RECIP_W'(RECIP);
  localparam logic [COEFF_W-1:0] ModC   = COEFF_W'(MODULUS);

  logic               a_valid_q;
  logic [COEFF_W-1:0] a_coeff_q;
  logic               b_valid_q;
  logic [COEFF_W-1:0] b_coeff_q;
  logic [PROD_W-1:0]  b_prod_q;
  value_t             c_q;
  value_t             c_d;

  logic [COEFF_W-1:0]   quot;
  logic [2*COEFF_W-1:0] quot_mod;
  logic [COEFF_W-1:0]   rem;
  logic [THR_W-1:0]     x;
  logic [VALUE_W:0]     hits;

  always_comb begin
    quot     = COEFF_W'(b_prod_q >> RECIP_SHIFT);
    quot_mod = quot * ModC;
    rem      = b_coeff_q - quot_mod[COEFF_W-1:0];
    x        = {1'b0, rem[MOD_W-1:0]};
    hits     = '0;
    for (int unsigned k = 1; k <= THR_COUNT; k++) begin
      if (x >= compress_threshold(k)) begin
        hits = hits + (VALUE_W+1)'(1);
      end
    end
    c_d.valid = b_valid_q;
    c_d.value = hits[VALUE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_q       <= '0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_q       <= c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_coeff_q <= coefficient_i;
      b_coeff_q <= a_coeff_q;
      b_prod_q  <= a_coeff_q * RecipC;
    end
  end

  assign value_o = c_q;

endmodule

`default_nettype wire

// ----- rtl/pcp_pack.sv -----
`default_nettype none

module pcp_pack
  import pcp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  value_t                 value_i,
  output logic                   out_valid_o,
  output logic [BYTE_W-1:0]      packed_byte_o,
  output logic                   last_byte_o
);

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(COEFF_COUNT - 1);

  logic [PEND_W-1:0] pend_q, pend_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] byte_q;
  logic              last_q;

  logic [BYTE_W+1:0] acc;
  logic [CNT_W:0]    sum;
  logic              is_final;
  logic              produce;

  always_comb begin
    acc      = (BYTE_W+2)'(pend_q) | ((BYTE_W+2)'(value_i.value) << cnt_q);
    sum      = (CNT_W+1)'(cnt_q) + (CNT_W+1)'(VALUE_W);
    is_final = (idx_q >= LastIdx);
    produce  = value_i.valid && sum[CNT_W];
    pend_d   = pend_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    if (value_i.valid) begin
      if (sum[CNT_W]) begin
        pend_d = PEND_W'(acc[BYTE_W+1:BYTE_W]);
        cnt_d  = sum[CNT_W-1:0];
      end else begin
        pend_d = acc[PEND_W-1:0];
        cnt_d  = sum[CNT_W-1:0];
      end
      idx_d = is_final ? '0 : idx_q + IDX_W'(1);
    end
    out_valid_d = produce;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && produce) begin
      byte_q <= acc[BYTE_W-1:0];
      last_q <= is_final;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign packed_byte_o = byte_q;
  assign last_byte_o   = last_q;

endmodule

`default_nettype wire

// ----- rtl/poly_compress_3bit_pack.sv -----
`default_nettype none

// Compresses 16-bit polynomial coefficients to 3 bits, round(8x/q) mod 8 after full
// reduction mod q, and packs them little-endian into bytes, first value in the low bits,
// three bytes per eight coefficients. last_byte_o flags a byte completed on the final
// coefficient of a polynomial; leftover bits are never flushed at a boundary. One
// coefficient is taken every cycle unless stalled; the completing coefficient of a byte
// passes the input register, reciprocal multiply, remainder and rounding compare, and
// pack and output register stages. While a byte waits at the output and out_stall_i is
// high, the whole pipeline holds and in_stall_o is raised.
module poly_compress_3bit_pack
  import pcp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [COEFF_W-1:0] coefficient_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [BYTE_W-1:0]       packed_byte_o,
  output logic                    last_byte_o
);

  logic   en;
  value_t value;

  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  pcp_reduce u_reduce (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (in_valid_i),
    .coefficient_i (coefficient_i),
    .value_o       (value)
  );

  pcp_pack u_pack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .value_i       (value),
    .out_valid_o   (out_valid_o),
    .packed_byte_o (packed_byte_o),
    .last_byte_o   (last_byte_o)
  );

endmodule

`default_nettype wire
